// ----- rtl/plc_pkg.sv -----
// shared constants, codes and control types for the positional list store
`default_nettype none

package plc_pkg;

	// default sizing
	localparam int CAPACITY_DEF  = 64;
	localparam int WORD_BITS_DEF = 32;

	// fixed field widths on the ports
	localparam int DATA_W   = 32;
	localparam int POS_W    = 7;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	// cells folded together in the first level of the read gather
	localparam int GATHER_GROUP = 8;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// per-cycle command broadcast along the cell chain
	typedef struct packed {
		logic shift_up;
		logic shift_down;
		logic pick;
	} plc_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/plc_cell.sv -----
// one storage cell of the chain: holds a word and trades it with its neighbours
`default_nettype none

module plc_cell #(
	parameter int WORD_BITS = plc_pkg::WORD_BITS_DEF,
	parameter int PW        = plc_pkg::POS_W,
	parameter int IDX       = 0
) (
	input  wire                        clk,
	input  wire plc_pkg::plc_ctrl_t    ctrl,
	input  wire logic [PW-1:0]         pos,
	input  wire logic [WORD_BITS-1:0]  ins_word,
	input  wire logic [WORD_BITS-1:0]  prev_word,
	input  wire logic [WORD_BITS-1:0]  next_word,
	output logic      [WORD_BITS-1:0]  word,
	output logic      [WORD_BITS-1:0]  pick_word
);
	import plc_pkg::*;

	logic [WORD_BITS-1:0] word_q;
	logic                 at_pos;
	logic                 above;

	// where this cell sits against the requested position
	assign at_pos = (PW'(IDX) == pos);
	assign above  = (PW'(IDX) > pos);

	// shift up on insert, down on remove, otherwise hold
	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			if (above) begin
				word_q <= prev_word;
			end else if (at_pos) begin
				word_q <= ins_word;
			end
		end else if (ctrl.shift_down && (above || at_pos)) begin
			word_q <= next_word;
		end
	end

	assign word      = word_q;
	// only the addressed cell drives its word towards the gather
	assign pick_word = (ctrl.pick && at_pos) ? word_q : '0;

endmodule

`default_nettype wire

// ----- rtl/plc_gather.sv -----
// two-level registered or-tree collecting the word picked out of the chain
`default_nettype none

module plc_gather #(
	parameter int CAPACITY  = plc_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = plc_pkg::WORD_BITS_DEF
) (
	input  wire                       clk,
	input  wire logic [WORD_BITS-1:0] pick [CAPACITY],
	output logic      [WORD_BITS-1:0] word
);
	import plc_pkg::*;

	localparam int NGRP = (CAPACITY + GATHER_GROUP - 1) / GATHER_GROUP;

	logic [WORD_BITS-1:0] grp_d  [NGRP];
	logic [WORD_BITS-1:0] grp_s1 [NGRP];
	logic [WORD_BITS-1:0] all_d;
	logic [WORD_BITS-1:0] word_s2;

	// first level: fold each group of cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GATHER_GROUP; k++) begin
				if (g * GATHER_GROUP + k < CAPACITY) begin
					grp_d[g] = grp_d[g] | pick[g * GATHER_GROUP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	// second level: fold the group results
	always_comb begin
		all_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			all_d = all_d | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= all_d;
	end

	assign word = word_s2;

endmodule

`default_nettype wire

// ----- rtl/positional_list_store.sv -----
// top level of the positional list store: control, cell chain and read gather
//
//  channel   direction  signals                          transfer when
//  request   in         start, kind, position, value     start high, busy low
//  result    out        done, data_out, status, count    done high (one cycle)
//
// A request transfers when start is high and busy is low; its result strobe is
// registered after the shift state and the gather state, and the next request
// can transfer in the cycle the strobe is high. The cell chain shifts in the shift
// state; the addressed word then passes the two registered levels of the or-tree.
// Reset clears the control state and the entry count only; cell contents are
// not reset. The receiver cannot stall; busy is high while a request is in work.
`default_nettype none

module positional_list_store #(
	parameter int CAPACITY  = plc_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = plc_pkg::WORD_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire logic        [plc_pkg::KIND_W-1:0]   kind,
	input  wire logic        [plc_pkg::POS_W-1:0]    position,
	input  wire logic signed [plc_pkg::DATA_W-1:0]   value,
	output logic                                  done,
	output logic signed      [plc_pkg::DATA_W-1:0]   data_out,
	output logic             [plc_pkg::STATUS_W-1:0] status,
	output logic             [plc_pkg::POS_W-1:0]    count
);
	import plc_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	localparam logic [1:0] FSM_IDLE   = 2'd0;
	localparam logic [1:0] FSM_SHIFT  = 2'd1;
	localparam logic [1:0] FSM_GATHER = 2'd2;

	logic [1:0]           state_q;
	logic                 done_q;
	logic [KIND_W-1:0]    kind_q;
	logic [POS_W-1:0]     pos_q;
	logic [WORD_BITS-1:0] ins_q;
	logic [CW-1:0]        count_q;
	logic [STATUS_W-1:0]  status_q;

	logic [WORD_BITS-1:0] ins_word;
	logic [PW-1:0]        pos_x;
	logic [PW-1:0]        cnt_x;
	logic [STATUS_W-1:0]  status_d;
	plc_ctrl_t            op_d;
	plc_ctrl_t            ctrl;
	logic                 accept;

	logic [WORD_BITS-1:0] cell_word [CAPACITY];
	logic [WORD_BITS-1:0] cell_pick [CAPACITY];
	logic [WORD_BITS-1:0] got_word;

	assign accept = start && !busy;
	assign busy   = (state_q != FSM_IDLE);

	// keep the low word bits of the inserted value, or zero-extend it to a wider word
	generate
		if (WORD_BITS <= DATA_W) begin : g_ins_cut
			assign ins_word = value[WORD_BITS-1:0];
		end else begin : g_ins_ext
			assign ins_word = {{(WORD_BITS-DATA_W){1'b0}}, value};
		end
	endgenerate

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			pos_q  <= position;
			ins_q  <= ins_word;
		end
	end

	// range and fullness checks against the current count
	assign pos_x = PW'(pos_q);
	assign cnt_x = PW'(count_q);

	always_comb begin
		status_d = STATUS_OK;
		op_d     = '0;
		unique case (kind_q)
			KIND_INSERT: begin
				if (pos_x > cnt_x) begin
					status_d = STATUS_RANGE;
				end else if (count_q == CW'(CAPACITY)) begin
					status_d = STATUS_FULL;
				end else begin
					op_d.shift_up = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (pos_x >= cnt_x) begin
					status_d = STATUS_RANGE;
				end else begin
					op_d.shift_down = 1'b1;
					op_d.pick       = 1'b1;
				end
			end
			KIND_READ: begin
				if (pos_x >= cnt_x) begin
					status_d = STATUS_RANGE;
				end else begin
					op_d.pick = 1'b1;
				end
			end
			default: begin
				status_d = STATUS_RANGE;
			end
		endcase
	end

	// the chain acts only in the shift cycle
	assign ctrl = (state_q == FSM_SHIFT) ? op_d : '0;

	// sequencer, count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				FSM_IDLE: begin
					if (start) begin
						state_q <= FSM_SHIFT;
					end
				end
				FSM_SHIFT: begin
					state_q <= FSM_GATHER;
					if (ctrl.shift_up) begin
						count_q <= count_q + CW'(1);
					end else if (ctrl.shift_down) begin
						count_q <= count_q - CW'(1);
					end
				end
				FSM_GATHER: begin
					state_q <= FSM_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_SHIFT) begin
			status_q <= status_d;
		end
	end

	// the cell chain
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [WORD_BITS-1:0] prev_w;
			logic [WORD_BITS-1:0] next_w;
			if (i == 0) begin : g_first
				assign prev_w = ins_q;
			end else begin : g_prev
				assign prev_w = cell_word[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign next_w = cell_word[i];
			end else begin : g_next
				assign next_w = cell_word[i+1];
			end
			plc_cell #(
				.WORD_BITS (WORD_BITS),
				.PW        (PW),
				.IDX       (i)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.pos       (pos_x),
				.ins_word  (ins_q),
				.prev_word (prev_w),
				.next_word (next_w),
				.word      (cell_word[i]),
				.pick_word (cell_pick[i])
			);
		end
	endgenerate

	// gather of the addressed word, taken before the shift lands
	plc_gather #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_gather (
		.clk  (clk),
		.pick (cell_pick),
		.word (got_word)
	);

	// sign-extend or cut the returned word to the port width; zero-extend or cut the count
	generate
		if (WORD_BITS >= DATA_W) begin : g_out_cut
			assign data_out = got_word[DATA_W-1:0];
		end else begin : g_out_ext
			assign data_out = {{(DATA_W-WORD_BITS){got_word[WORD_BITS-1]}}, got_word};
		end
		if (CW >= POS_W) begin : g_cnt_cut
			assign count = count_q[POS_W-1:0];
		end else begin : g_cnt_ext
			assign count = {{(POS_W-CW){1'b0}}, count_q};
		end
	endgenerate

	assign done   = done_q;
	assign status = status_q;

endmodule

`default_nettype wire

// ----- rtl/plc_checker.sv -----
// port-level checks of the positional list store, bound to the top level
`default_nettype none

module plc_checker #(
	parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 start,
	input wire                                 busy,
	input wire                                 done,
	input wire logic [plc_pkg::STATUS_W-1:0]   status,
	input wire logic [plc_pkg::POS_W-1:0]      count
);
	import plc_pkg::*;

	// a transfer always yields its result strobe
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("no result three cycles after a request transfer");

	// no result strobe without a matching earlier request transfer
	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result strobe without a matching request");

	// the block is busy while a request is in work
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 busy ##1 !busy)
		else $error("busy does not cover the request");

	// a full refusal only when the store is full
	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_FULL) |-> (count == POS_W'(CAPACITY)))
		else $error("store full reported below capacity");

	// status holds a defined code on every result
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STATUS_OK || status == STATUS_RANGE || status == STATUS_FULL))
		else $error("undefined status code on a result");

endmodule

bind positional_list_store plc_checker #(
	.CAPACITY (CAPACITY)
) u_plc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status),
	.count  (count)
);

`default_nettype wire
